// ===== rtl/dpb_pkg.sv =====
// ----------------------------------------------------------------------------
// dpb_pkg - shared types and constants
// Register codes, reset values and the per-beat side data that travels
// alongside the divider chain.
// ----------------------------------------------------------------------------
package dpb_pkg;

  // default parameter values
  localparam int COORD_BITS_DEF = 12;
  localparam int FRAC_BITS_DEF  = 16;

  // quotient bits resolved by the divider chain (one per cell)
  localparam int QUOT_BITS = 33;
  localparam int DEN_W     = 32;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_COL = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_ROW = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_COL  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FOCAL_ROW  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DEPTH_SCALE = 3'd4;

  localparam logic [15:0] RST_CENTER_COL  = 16'd5120;
  localparam logic [15:0] RST_CENTER_ROW  = 16'd3840;
  localparam logic [15:0] RST_FOCAL_COL   = 16'd8400;
  localparam logic [15:0] RST_FOCAL_ROW   = 16'd8400;
  localparam logic [15:0] RST_DEPTH_SCALE = 16'd5000;

  // lane numbering inside the divider
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // data that rides along with a beat but is not divided
  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       neg_x;
    logic       neg_y;
    logic [2:0] ovf;
  } side_t;

  // one finished point
  typedef struct packed {
    logic [31:0] point_x;
    logic [31:0] point_y;
    logic [31:0] point_z;
    logic [7:0]  blue;
    logic [7:0]  green;
    logic [7:0]  red;
  } point_t;

endpackage

// ===== rtl/dpb_cell.sv =====
// ----------------------------------------------------------------------------
// dpb_cell - one restoring-division cell
// Resolves one quotient bit: shifts in a numerator bit, trial-subtracts the
// divisor and hands remainder, quotient and operands to the next cell.
// ----------------------------------------------------------------------------
module dpb_cell
  import dpb_pkg::*;
#(
  parameter int BIT = 0
) (
  input  logic                 clk,
  input  logic                 en,
  input  logic [DEN_W-1:0]     den_in,
  input  logic [QUOT_BITS-1:0] num_in,
  input  logic [DEN_W-1:0]     rem_in,
  input  logic [QUOT_BITS-1:0] quot_in,
  output logic [DEN_W-1:0]     den_out,
  output logic [QUOT_BITS-1:0] num_out,
  output logic [DEN_W-1:0]     rem_out,
  output logic [QUOT_BITS-1:0] quot_out
);

  logic [DEN_W:0]       trial;
  logic                 fits;
  logic [DEN_W-1:0]     rem_next;
  logic [QUOT_BITS-1:0] quot_next;

  // trial subtract
  always_comb begin
    trial     = {rem_in, num_in[BIT]};
    fits      = trial >= {1'b0, den_in};
    rem_next  = fits ? DEN_W'(trial - {1'b0, den_in}) : trial[DEN_W-1:0];
    quot_next = quot_in;
    quot_next[BIT] = fits;
  end

  // hand off to the neighbor
  always_ff @(posedge clk) begin
    if (en) begin
      den_out  <= den_in;
      num_out  <= num_in;
      rem_out  <= rem_next;
      quot_out <= quot_next;
    end
  end

endmodule

// ===== rtl/depth_pixel_backprojection.sv =====
// ----------------------------------------------------------------------------
// depth_pixel_backprojection - pinhole back-projection of depth pixels
// Turns a depth pixel with its column, row and color into a 3-D point.
// ----------------------------------------------------------------------------
//  channel | handshake                | payload
//  --------+--------------------------+-------------------------------------
//  input   | in_valid / in_stall      | col row depth blue green red
//  output  | out_valid / out_stall    | point_x point_y point_z out_* color
//  config  | cfg_we                   | cfg_index cfg_data
//
//  One beat per cycle while in_stall is low; beats pass stages 1 to 4, then
//  the chain of one-bit division cells (three lanes x, y, z side by side), then out_r.
//  Zero-depth beats are accepted and dropped at the front.
//  Reset clears valids and the skid stage and loads the camera defaults.
//  A stalled output fills the skid stage; only then is in_stall raised.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection
  import dpb_pkg::*;
#(
  parameter int COORD_BITS = COORD_BITS_DEF,
  parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [11:0]          col,
  input  logic [11:0]          row,
  input  logic [15:0]          depth,
  input  logic [7:0]           blue,
  input  logic [7:0]           green,
  input  logic [7:0]           red,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          point_x,
  output logic [31:0]          point_y,
  output logic [31:0]          point_z,
  output logic [7:0]           out_blue,
  output logic [7:0]           out_green,
  output logic [7:0]           out_red
);

  localparam int NW = QUOT_BITS + FRAC_BITS;       // rounded numerator width
  localparam logic [11:0] CMASK = 12'((64'd1 << COORD_BITS) - 64'd1);
  localparam int LAST = QUOT_BITS;

  // camera registers
  logic [15:0] center_col, center_row, focal_col, focal_row, depth_scale;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_col  <= RST_CENTER_COL;
      center_row  <= RST_CENTER_ROW;
      focal_col   <= RST_FOCAL_COL;
      focal_row   <= RST_FOCAL_ROW;
      depth_scale <= RST_DEPTH_SCALE;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CENTER_COL:  center_col  <= cfg_data;
        REG_CENTER_ROW:  center_row  <= cfg_data;
        REG_FOCAL_COL:   focal_col   <= cfg_data;
        REG_FOCAL_ROW:   focal_row   <= cfg_data;
        REG_DEPTH_SCALE: depth_scale <= cfg_data;
        default: ;
      endcase
    end
  end

  logic skid_full;
  logic en;
  assign en       = !skid_full;
  assign in_stall = skid_full;

  // stage 1: offsets from the principal point, nonzero divisors
  logic [15:0] pos_x, pos_y;
  assign pos_x = {4'(0), col & CMASK} << 4;
  assign pos_y = {4'(0), row & CMASK} << 4;

  logic        v1;
  logic [15:0] mag_x1, mag_y1, dep1, scl1, fcol1, frow1;
  side_t       side1;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= in_valid && (depth != 16'd0);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side1  <= '{blue: blue, green: green, red: red,
                  neg_x: (pos_x < center_col), neg_y: (pos_y < center_row),
                  ovf: 3'b000};
      mag_x1 <= (pos_x < center_col) ? center_col - pos_x : pos_x - center_col;
      mag_y1 <= (pos_y < center_row) ? center_row - pos_y : pos_y - center_row;
      dep1   <= depth;
      scl1   <= (depth_scale == 16'd0) ? 16'd1 : depth_scale;
      fcol1  <= (focal_col == 16'd0) ? 16'd1 : focal_col;
      frow1  <= (focal_row == 16'd0) ? 16'd1 : focal_row;
    end
  end

  // stage 2: products
  logic        v2;
  logic [31:0] prod_x2, prod_y2, den_x2, den_y2;
  logic [15:0] dep2, scl2;
  side_t       side2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_x2 <= mag_x1 * dep1;
      prod_y2 <= mag_y1 * dep1;
      den_x2  <= scl1 * fcol1;
      den_y2  <= scl1 * frow1;
      dep2    <= dep1;
      scl2    <= scl1;
      side2   <= side1;
    end
  end

  // stage 3: scaled numerators with half divisor for rounding
  logic          v3;
  logic [NW-1:0] num3 [0:2];
  logic [31:0]   den3 [0:2];
  side_t         side3;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else if (en) v3 <= v2;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      num3[LANE_X] <= NW'({prod_x2, {FRAC_BITS{1'b0}}}) + NW'(den_x2[31:1]);
      num3[LANE_Y] <= NW'({prod_y2, {FRAC_BITS{1'b0}}}) + NW'(den_y2[31:1]);
      num3[LANE_Z] <= NW'({dep2, {FRAC_BITS{1'b0}}}) + NW'(scl2[15:1]);
      den3[LANE_X] <= den_x2;
      den3[LANE_Y] <= den_y2;
      den3[LANE_Z] <= 32'(scl2);
      side3        <= side2;
    end
  end

  // stage 4: quotient overflow check, initial remainder
  logic                 v4;
  logic [DEN_W-1:0]     den_c  [0:LAST][0:2];
  logic [QUOT_BITS-1:0] num_c  [0:LAST][0:2];
  logic [DEN_W-1:0]     rem_c  [0:LAST][0:2];
  logic [QUOT_BITS-1:0] quot_c [0:LAST][0:2];
  logic                 vld_c  [0:LAST];
  side_t                side_c [0:LAST];
  side_t                side3o;

  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else if (en) v4 <= v3;
  end

  // quotient would not fit the chain when the upper part reaches the divisor
  always_comb begin
    side3o = side3;
    for (int l = 0; l < 3; l++) begin
      side3o.ovf[l] = DEN_W'(num3[l][NW-1:QUOT_BITS]) >= den3[l];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_c[0] <= side3o;
      for (int l = 0; l < 3; l++) begin
        rem_c[0][l]  <= DEN_W'(num3[l][NW-1:QUOT_BITS]);
        num_c[0][l]  <= num3[l][QUOT_BITS-1:0];
        den_c[0][l]  <= den3[l];
        quot_c[0][l] <= '0;
      end
    end
  end
  assign vld_c[0] = v4;

  // chain of division cells, most significant quotient bit first
  for (genvar k = 0; k < LAST; k++) begin : g_cell
    for (genvar l = 0; l < 3; l++) begin : g_lane
      dpb_cell #(.BIT(QUOT_BITS - 1 - k)) u_cell (
        .clk      (clk),
        .en       (en),
        .den_in   (den_c[k][l]),
        .num_in   (num_c[k][l]),
        .rem_in   (rem_c[k][l]),
        .quot_in  (quot_c[k][l]),
        .den_out  (den_c[k+1][l]),
        .num_out  (num_c[k+1][l]),
        .rem_out  (rem_c[k+1][l]),
        .quot_out (quot_c[k+1][l])
      );
    end
    logic  v_r;
    side_t s_r;
    always_ff @(posedge clk) begin
      if (rst) v_r <= 1'b0;
      else if (en) v_r <= vld_c[k];
    end
    always_ff @(posedge clk) begin
      if (en) s_r <= side_c[k];
    end
    assign vld_c[k+1]  = v_r;
    assign side_c[k+1] = s_r;
  end

  // saturation and sign
  function automatic logic [31:0] sat_signed(input logic [QUOT_BITS-1:0] q,
                                             input logic ovf, input logic neg);
    logic big;
    big = ovf || (q[QUOT_BITS-1:31] != '0);
    if (big) return neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
    return neg ? 32'(-q[31:0]) : q[31:0];
  endfunction

  point_t fin, out_r, skid_r;
  side_t  sf;
  assign sf = side_c[LAST];

  always_comb begin
    fin.point_x = sat_signed(quot_c[LAST][LANE_X], sf.ovf[LANE_X], sf.neg_x);
    fin.point_y = sat_signed(quot_c[LAST][LANE_Y], sf.ovf[LANE_Y], sf.neg_y);
    fin.point_z = (sf.ovf[LANE_Z] || quot_c[LAST][LANE_Z][QUOT_BITS-1])
                  ? 32'hFFFF_FFFF : quot_c[LAST][LANE_Z][31:0];
    fin.blue  = sf.blue;
    fin.green = sf.green;
    fin.red   = sf.red;
  end

  // output register with skid stage
  logic out_free;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      skid_full <= 1'b0;
    end else if (skid_full) begin
      if (out_free) begin
        out_valid <= 1'b1;
        skid_full <= 1'b0;
      end
    end else if (vld_c[LAST]) begin
      if (out_free) out_valid <= 1'b1;
      else skid_full <= 1'b1;
    end else if (out_valid && !out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_full) begin
      if (out_free) out_r <= skid_r;
    end else if (vld_c[LAST]) begin
      if (out_free) out_r <= fin;
      else skid_r <= fin;
    end
  end

  assign point_x   = out_r.point_x;
  assign point_y   = out_r.point_y;
  assign point_z   = out_r.point_z;
  assign out_blue  = out_r.blue;
  assign out_green = out_r.green;
  assign out_red   = out_r.red;

  // checks
  a_skid_implies_out: assert property (@(posedge clk) disable iff (rst)
    skid_full |-> out_valid) else $error("skid holds a beat with output empty");

  a_front_valid: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall && depth != 16'd0) |=> v1)
    else $error("accepted nonzero depth beat lost at front");

  a_skid_cause: assert property (@(posedge clk) disable iff (rst)
    $rose(skid_full) |-> $past(out_valid && out_stall))
    else $error("skid filled without output stall");

endmodule

// ===== tb/sv/depth_pixel_backprojection_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// depth_pixel_backprojection_test - self-checking bench for the back-projector
// Drives depth pixels with random gaps, predicts each 3-D point in fixed
// point, and compares every output beat with the oldest predicted point.
// ----------------------------------------------------------------------------
module depth_pixel_backprojection_test;
  import dpb_pkg::*;

  localparam int LATENCY = 4 + QUOT_BITS + 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [11:0] col = '0, row = '0;
  logic [15:0] depth = '0;
  logic [7:0] blue = '0, green = '0, red = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [31:0] point_x, point_y, point_z;
  logic [7:0] out_blue, out_green, out_red;

  // camera registers as the bench sees them
  logic [15:0] cam_ccol, cam_crow, cam_fcol, cam_frow, cam_scale;

  point_t pending_points[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_cycles = 0;

  always #6 clk = ~clk;

  depth_pixel_backprojection u_dut (.*);

  // signed offset times depth over den, rounded, saturated to 32 bits
  function automatic logic [31:0] project_axis(logic [11:0] pix, logic [15:0] center,
                                               logic [15:0] dep, logic [63:0] den);
    logic [63:0] pos, mag, num, q;
    logic neg;
    pos = {52'd0, pix} << 4;
    neg = pos < {48'd0, center};
    mag = neg ? {48'd0, center} - pos : pos - {48'd0, center};
    num = (mag * dep) << 16;
    q = (num + den / 2) / den;
    if (neg) return (q >= 64'h8000_0000) ? 32'h8000_0000 : 32'(-q);
    return (q > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
  endfunction

  function automatic point_t backproject(logic [11:0] c, logic [11:0] r, logic [15:0] d,
                                         logic [7:0] b, logic [7:0] g, logic [7:0] rd);
    point_t p;
    logic [63:0] sc, fc, fr, z;
    sc = (cam_scale == 0) ? 64'd1 : 64'(cam_scale);
    fc = (cam_fcol == 0) ? 64'd1 : 64'(cam_fcol);
    fr = (cam_frow == 0) ? 64'd1 : 64'(cam_frow);
    z = ((64'(d) << 16) + sc / 2) / sc;
    p.point_z = (z > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : z[31:0];
    p.point_x = project_axis(c, cam_ccol, d, sc * fc);
    p.point_y = project_axis(r, cam_crow, d, sc * fr);
    p.blue = b;
    p.green = g;
    p.red = rd;
    return p;
  endfunction

  // receiver stall: random, or a long counted hold-off
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // output checker
  always @(posedge clk) begin
    point_t exp_pt;
    if (!rst && out_valid && !out_stall) begin
      if (pending_points.size() == 0) begin
        $error("unexpected point beat x=%h y=%h z=%h", point_x, point_y, point_z);
        errors++;
      end else begin
        exp_pt = pending_points.pop_front();
        if (point_x !== exp_pt.point_x) begin
          $error("point_x exp %h got %h", exp_pt.point_x, point_x); errors++;
        end
        if (point_y !== exp_pt.point_y) begin
          $error("point_y exp %h got %h", exp_pt.point_y, point_y); errors++;
        end
        if (point_z !== exp_pt.point_z) begin
          $error("point_z exp %h got %h", exp_pt.point_z, point_z); errors++;
        end
        if (out_blue !== exp_pt.blue) begin
          $error("out_blue exp %h got %h", exp_pt.blue, out_blue); errors++;
        end
        if (out_green !== exp_pt.green) begin
          $error("out_green exp %h got %h", exp_pt.green, out_green); errors++;
        end
        if (out_red !== exp_pt.red) begin
          $error("out_red exp %h got %h", exp_pt.red, out_red); errors++;
        end
      end
    end
  end

  // one pixel beat; returns after it is accepted, valid left high
  task automatic send_pixel(logic [11:0] c, logic [11:0] r, logic [15:0] d,
                            logic [7:0] b, logic [7:0] g, logic [7:0] rd);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    col <= c; row <= r; depth <= d; blue <= b; green <= g; red <= rd;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    if (d != 0) pending_points.insert(pending_points.size(), backproject(c, r, d, b, g, rd));
    @(negedge clk);
  endtask

  task automatic send_random_pixel();
    logic [15:0] d;
    case ($urandom_range(9))
      0: d = 16'd0;
      1: d = 16'hFFFF;
      2: d = 16'($urandom_range(1, 15));
      default: d = 16'($urandom);
    endcase
    send_pixel(12'($urandom), 12'($urandom), d, 8'($urandom), 8'($urandom),
               8'($urandom));
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
    cfg_we <= 1'b1; cfg_index <= idx; cfg_data <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_CENTER_COL: cam_ccol = val;
      REG_CENTER_ROW: cam_crow = val;
      REG_FOCAL_COL: cam_fcol = val;
      REG_FOCAL_ROW: cam_frow = val;
      REG_DEPTH_SCALE: cam_scale = val;
      default: ;
    endcase
  endtask

  // wait until all points are out, then let the pipe drain dropped beats
  task automatic drain();
    in_valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (LATENCY + 4) @(negedge clk);
  endtask

  task automatic set_camera(logic [15:0] cc, logic [15:0] cr, logic [15:0] fc,
                            logic [15:0] fr, logic [15:0] sc);
    drain();
    write_reg(REG_CENTER_COL, cc);
    write_reg(REG_CENTER_ROW, cr);
    write_reg(REG_FOCAL_COL, fc);
    write_reg(REG_FOCAL_ROW, fr);
    write_reg(REG_DEPTH_SCALE, sc);
  endtask

  // field extremes and zero depth at reset camera values, then saturation with other cameras
  task automatic test_directed();
    send_pixel(12'd0, 12'd0, 16'd0, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd0, 12'd0, 16'd1, 8'h00, 8'h00, 8'h00);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'hFF, 8'hFF, 8'hFF);
    send_pixel(12'd320, 12'd240, 16'd5000, 8'h12, 8'h34, 8'h56);
    send_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'hA5, 8'h5A, 8'h0F);
    send_pixel(12'hFFF, 12'd0, 16'd1, 8'hF0, 8'h0F, 8'hAA);
    send_pixel(12'h555, 12'hAAA, 16'h5555, 8'h55, 8'hAA, 8'h55);
    send_pixel(12'hAAA, 12'h555, 16'hAAAA, 8'hAA, 8'h55, 8'hAA);
    // zero divisors, unit camera: large z and saturating x, y
    set_camera(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
    send_pixel(12'hFFF, 12'hFFF, 16'hFFFF, 8'h01, 8'h02, 8'h03);
    send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h04, 8'h05, 8'h06);
    set_camera(16'hFFFF, 16'hFFFF, 16'd1, 16'd1, 16'd1);
    send_pixel(12'd0, 12'd0, 16'hFFFF, 8'h07, 8'h08, 8'h09);
    send_pixel(12'hFFF, 12'hFFF, 16'd1, 8'h0A, 8'h0B, 8'h0C);
    set_camera(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
    send_pixel(12'd0, 12'hFFF, 16'hFFFF, 8'h0D, 8'h0E, 8'h0F);
    send_pixel(12'd0, 12'd0, 16'd1, 8'h10, 8'h11, 8'h12);
    // unknown register index is ignored
    drain();
    write_reg(3'd7, 16'h1234);
    write_reg(3'd5, 16'h4321);
    send_pixel(12'd100, 12'd100, 16'd300, 8'h13, 8'h14, 8'h15);
  endtask

  task automatic test_random_camera(int n);
    set_camera(16'($urandom), 16'($urandom), 16'($urandom_range(1, 65535)),
               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
    repeat (n) send_random_pixel();
  endtask

  // long output hold-off while pixels keep coming
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_cycles = 200;
    repeat (120) send_random_pixel();
  endtask

  initial begin
    cam_ccol = RST_CENTER_COL; cam_crow = RST_CENTER_ROW;
    cam_fcol = RST_FOCAL_COL; cam_frow = RST_FOCAL_ROW; cam_scale = RST_DEPTH_SCALE;
    repeat (12) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    test_directed();
    // realistic camera, each idling phase
    set_camera(16'd5120, 16'd3840, 16'd8400, 16'd8400, 16'd5000);
    send_idle_pct = 0; recv_stall_pct = 0;
    repeat (300) send_random_pixel();
    send_idle_pct = 74; recv_stall_pct = 0;
    test_random_camera(250);
    send_idle_pct = 0; recv_stall_pct = 74;
    test_random_camera(250);
    send_idle_pct = 17; recv_stall_pct = 17;
    test_random_camera(250);
    test_backpressure();
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random_camera(200);
    set_camera(16'($urandom), 16'($urandom), 16'd1, 16'hFFFF, 16'd1);
    repeat (100) send_random_pixel();
    drain();
    if (errors == 0) begin
      $display("depth_pixel_backprojection_test OK");
    end else begin
      $display("depth_pixel_backprojection_test NOT OK");
    end
    $finish;
  end

  // watchdog
  initial begin
    #20ms;
    $display("depth_pixel_backprojection_test NOT OK");
    $finish;
  end

endmodule
